FILE: design/mbd_pkg.sv
// Shared types, codes and the CRC-16 update for the Modbus response deframer.
// No dependencies; imported by every module of the block.
package mbd_pkg;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_GOOD    = 2'd1;
  localparam logic [1:0] ST_CRC_ERR = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [1:0] REG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] REG_FUNC_CODE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  localparam logic [7:0]  DEV_ADDR_RST  = 8'd1;
  localparam logic [7:0]  FUNC_CODE_RST = 8'd3;
  localparam logic [15:0] TIMEOUT_RST   = 16'd2000;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int RES_FIFO_DEPTH = 4;
  localparam int RES_PTR_W      = 2;
  localparam int RES_LVL_W      = 3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [8:0] byte_index;
    logic       last;
    logic [1:0] status;
  } mbd_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    mbd_res_t   r0;
    mbd_res_t   r1;
  } mbd_push_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/modbus_response_deframer_core.sv
// Modbus RTU response deframer top: input register, frame parser, timer, result queue.
// Throughput: 1 request per cycle; a header match gives 2 results, which the result
// queue drains at 1 per cycle while out_ready_i is high, so input stalls only while
// the queue backs up.
// Reset: rst_ni asynchronous, active low; config returns to address 1, function 3,
// timeout 2000, parser hunts for the address, timer disarmed, queue empty.
module modbus_response_deframer_core #(
  parameter int MAX_PAYLOAD = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic [8:0]  byte_index_o,
  output logic        last_o,
  output logic [1:0]  status_o
);
  import mbd_pkg::*;

  logic [7:0]           dev_addr_q;
  logic [7:0]           func_code_q;
  logic [15:0]          timeout_q;
  logic                 in_valid_q;
  logic [1:0]           cmd_q;
  logic [7:0]           byte_q;
  logic                 consume;
  logic                 byte_consume;
  logic                 frame_end;
  logic                 tmr_hit;
  logic                 tmr_waiting;
  logic                 pop;
  mbd_push_t            dfr_push;
  mbd_push_t            push;
  mbd_res_t             head;
  logic [RES_LVL_W-1:0] fifo_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DEV_ADDR_RST;
      func_code_q <= FUNC_CODE_RST;
      timeout_q   <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEV_ADDR:  dev_addr_q  <= cfg_data_i[7:0];
        REG_FUNC_CODE: func_code_q <= cfg_data_i[7:0];
        REG_TIMEOUT:   timeout_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign consume      = in_valid_q && (fifo_level <= RES_LVL_W'(RES_FIFO_DEPTH - 2));
  assign in_ready_o   = !in_valid_q || consume;
  assign byte_consume = consume && (cmd_q == CMD_BYTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= command_i;
      byte_q <= data_byte_i;
    end
  end

  mbd_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_deframer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .consume_i  (byte_consume),
    .data_i     (byte_q),
    .dev_addr_i (dev_addr_q),
    .func_code_i(func_code_q),
    .push_o     (dfr_push),
    .frame_end_o(frame_end)
  );

  mbd_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .consume_i  (consume),
    .command_i  (cmd_q),
    .frame_end_i(frame_end),
    .timeout_i  (timeout_q),
    .hit_o      (tmr_hit),
    .waiting_o  (tmr_waiting)
  );

  always_comb begin
    push = dfr_push;
    if (tmr_hit) begin
      push.cnt = 2'd1;
      push.r0  = '{frame_byte: 8'd0, byte_index: 9'd0, last: 1'b1, status: ST_TIMEOUT};
      push.r1  = '0;
    end
  end

  assign pop = out_valid_o && out_ready_i;

  mbd_res_fifo u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .level_o(fifo_level)
  );

  assign out_valid_o  = (fifo_level != '0);
  assign frame_byte_o = head.frame_byte;
  assign byte_index_o = head.byte_index;
  assign last_o       = head.last;
  assign status_o     = head.status;

`ifndef NO_ASSERTIONS
  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_level <= RES_LVL_W'(RES_FIFO_DEPTH))
    else $error("result queue overflow");

  a_start_arms_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && (cmd_q == CMD_START) |=> tmr_waiting)
    else $error("start did not arm the timer");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && (fifo_level > RES_LVL_W'(RES_FIFO_DEPTH - 2)))
    else $error("input stalled without a full queue");

  a_timeout_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmr_hit |-> consume && (cmd_q == CMD_TICK) && !frame_end)
    else $error("timeout outside a tick request");
`endif

endmodule

FILE: design/mbd_deframer.sv
// Frame parser: header hunt, byte count, payload and CRC-16 check.
// Depends on mbd_pkg for result types and the CRC update.
module mbd_deframer #(
  parameter int MAX_PAYLOAD = 255
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              consume_i,
  input  logic [7:0]        data_i,
  input  logic [7:0]        dev_addr_i,
  input  logic [7:0]        func_code_i,
  output mbd_pkg::mbd_push_t push_o,
  output logic              frame_end_o
);
  import mbd_pkg::*;

  localparam int CntW = $clog2(MAX_PAYLOAD + 1);

  localparam logic [2:0] PH_ADDR    = 3'd0;
  localparam logic [2:0] PH_FUNC    = 3'd1;
  localparam logic [2:0] PH_COUNT   = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC1    = 3'd4;
  localparam logic [2:0] PH_CRC2    = 3'd5;

  logic [2:0]      phase_q, phase_d;
  logic [15:0]     crc_q, crc_d;
  logic [CntW-1:0] left_q, left_d;
  logic [8:0]      pos_q, pos_d;
  logic [7:0]      first_q, first_d;
  logic [15:0]     crc_nxt;
  logic [15:0]     hdr_crc;
  logic [CntW-1:0] count_clamped;
  logic            good;

  assign crc_nxt = crc16_update(crc_q, data_i);
  assign hdr_crc = crc16_update(crc16_update(CRC_INIT, dev_addr_i), data_i);
  assign count_clamped = ({1'b0, data_i} > 9'(MAX_PAYLOAD)) ? CntW'(MAX_PAYLOAD)
                                                             : CntW'(data_i);
  assign good = (first_q == crc_q[7:0]) && (data_i == crc_q[15:8]);

  always_comb begin
    phase_d     = phase_q;
    crc_d       = crc_q;
    left_d      = left_q;
    pos_d       = pos_q;
    first_d     = first_q;
    push_o      = '0;
    frame_end_o = 1'b0;
    if (consume_i) begin
      case (phase_q)
        PH_ADDR: begin
          if (data_i == dev_addr_i) begin
            phase_d = PH_FUNC;
          end
        end
        PH_FUNC: begin
          if (data_i == func_code_i) begin
            crc_d     = hdr_crc;
            push_o.cnt = 2'd2;
            push_o.r0 = '{frame_byte: dev_addr_i, byte_index: 9'd0, last: 1'b0,
                          status: ST_BUSY};
            push_o.r1 = '{frame_byte: data_i, byte_index: 9'd1, last: 1'b0,
                          status: ST_BUSY};
            pos_d     = 9'd2;
            phase_d   = PH_COUNT;
          end else if (data_i != dev_addr_i) begin
            phase_d = PH_ADDR;
          end
        end
        PH_COUNT: begin
          crc_d      = crc_nxt;
          push_o.cnt = 2'd1;
          push_o.r0  = '{frame_byte: data_i, byte_index: pos_q, last: 1'b0,
                         status: ST_BUSY};
          pos_d      = pos_q + 9'd1;
          left_d     = count_clamped;
          phase_d    = (count_clamped == '0) ? PH_CRC1 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc_d      = crc_nxt;
          push_o.cnt = 2'd1;
          push_o.r0  = '{frame_byte: data_i, byte_index: pos_q, last: 1'b0,
                         status: ST_BUSY};
          pos_d      = pos_q + 9'd1;
          if (left_q != '0) begin
            left_d = left_q - CntW'(1);
          end
          if (left_q <= CntW'(1)) begin
            phase_d = PH_CRC1;
          end
        end
        PH_CRC1: begin
          first_d    = data_i;
          push_o.cnt = 2'd1;
          push_o.r0  = '{frame_byte: data_i, byte_index: pos_q, last: 1'b0,
                         status: ST_BUSY};
          pos_d      = pos_q + 9'd1;
          phase_d    = PH_CRC2;
        end
        PH_CRC2: begin
          push_o.cnt  = 2'd1;
          push_o.r0   = '{frame_byte: data_i, byte_index: pos_q, last: 1'b1,
                          status: good ? ST_GOOD : ST_CRC_ERR};
          phase_d     = PH_ADDR;
          crc_d       = CRC_INIT;
          left_d      = '0;
          pos_d       = '0;
          frame_end_o = 1'b1;
        end
        default: begin
          phase_d = PH_ADDR;
          crc_d   = CRC_INIT;
          left_d  = '0;
          pos_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ADDR;
      crc_q   <= CRC_INIT;
      left_q  <= '0;
      pos_q   <= '0;
      first_q <= '0;
    end else begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      first_q <= first_d;
    end
  end

endmodule

FILE: design/mbd_timer.sv
// Response timer: armed by start, advanced by ticks, reports a timeout.
// Depends on mbd_pkg for command codes.
module mbd_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        consume_i,
  input  logic [1:0]  command_i,
  input  logic        frame_end_i,
  input  logic [15:0] timeout_i,
  output logic        hit_o,
  output logic        waiting_o
);
  import mbd_pkg::*;

  logic        waiting_q, waiting_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] tick_inc;

  assign tick_inc  = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
  assign waiting_o = waiting_q;

  always_comb begin
    waiting_d = waiting_q;
    tick_d    = tick_q;
    hit_o     = 1'b0;
    if (consume_i) begin
      if (command_i == CMD_START) begin
        waiting_d = 1'b1;
        tick_d    = '0;
      end else if (command_i == CMD_TICK && waiting_q) begin
        tick_d = tick_inc;
        if (tick_inc >= timeout_i) begin
          waiting_d = 1'b0;
          hit_o     = 1'b1;
        end
      end
    end
    if (frame_end_i) begin
      waiting_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      tick_q    <= '0;
    end else begin
      waiting_q <= waiting_d;
      tick_q    <= tick_d;
    end
  end

endmodule

FILE: design/mbd_res_fifo.sv
// Result queue: takes up to two results a cycle, hands out one a cycle when popped.
// Depends on mbd_pkg for the result types and queue depth.
module mbd_res_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mbd_pkg::mbd_push_t              push_i,
  input  logic                            pop_i,
  output mbd_pkg::mbd_res_t               head_o,
  output logic [mbd_pkg::RES_LVL_W-1:0]   level_o
);
  import mbd_pkg::*;

  mbd_res_t               mem_q [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [RES_PTR_W-1:0]   wr_ptr_1;
  logic [RES_LVL_W-1:0]   level_q;

  assign wr_ptr_1 = wr_ptr_q + RES_PTR_W'(1);
  assign head_o   = mem_q[rd_ptr_q];
  assign level_o  = level_q;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_i.cnt);
      rd_ptr_q <= rd_ptr_q + RES_PTR_W'(pop_i);
      level_q  <= level_q + RES_LVL_W'(push_i.cnt) - RES_LVL_W'(pop_i);
    end
  end

endmodule

FILE: verif/modbus_response_deframer_core_test.sv
// Self-checking testbench for modbus_response_deframer_core: sends byte, tick and start
// requests, keeps a cycle-free model of the deframer and timer, and checks every result.
// Depends on mbd_pkg and the deframer RTL.
module modbus_response_deframer_core_test;
  import mbd_pkg::*;

  localparam logic [1:0]      CMD_UNUSED     = 2'd3;
  localparam int unsigned     PAYLOAD_LIMIT  = 255;
  localparam int unsigned     TOTAL_REQUESTS = 1550;
  localparam int unsigned     WHOLE_FRAME    = 1024;
  localparam int unsigned     HOLD_CYCLES    = 400;
  localparam int unsigned     SETTLE_CYCLES  = 8;
  localparam longint unsigned CYCLE_LIMIT    = 200000;

  typedef enum logic [2:0] {
    HUNT_ADDR, HUNT_FUNC, TAKE_COUNT, TAKE_PAYLOAD, TAKE_CRC_LO, TAKE_CRC_HI
  } parse_phase_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = REG_DEV_ADDR;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i   = CMD_BYTE;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  frame_byte_o;
  logic [8:0]  byte_index_o;
  logic        last_o;
  logic [1:0]  status_o;

  logic [7:0]   addr_cfg;
  logic [7:0]   func_cfg;
  logic [15:0]  tmo_cfg;
  parse_phase_e parse_phase;
  logic [15:0]  frame_crc;
  logic [8:0]   payload_left;
  logic [8:0]   frame_pos;
  logic [7:0]   crc_lo_rx;
  bit           timer_armed;
  logic [15:0]  tick_cnt;
  mbd_res_t     frame_results[$];
  mbd_res_t     next_result;

  bit          idle_on        = 1'b1;
  bit          sprinkle_timer = 1'b0;
  bit          hold_active    = 1'b0;
  event        hold_trigger;
  int unsigned requests_counted;
  int unsigned configs_loaded;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned good_frames;
  int unsigned crc_errors;
  int unsigned timeouts;
  longint unsigned cycle_count;

  modbus_response_deframer_core #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_byte_o(frame_byte_o),
    .byte_index_o(byte_index_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = {1'b0, c[15:1]};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void restart_hunt();
    parse_phase  = HUNT_ADDR;
    frame_crc    = CRC_INIT;
    payload_left = '0;
    frame_pos    = '0;
  endfunction

  function automatic void reset_prediction();
    addr_cfg    = DEV_ADDR_RST;
    func_cfg    = FUNC_CODE_RST;
    tmo_cfg     = TIMEOUT_RST;
    restart_hunt();
    crc_lo_rx   = '0;
    timer_armed = 1'b0;
    tick_cnt    = '0;
  endfunction

  function automatic void add_frame_result(input logic [7:0] b, input logic [8:0] idx,
                                           input logic lst, input logic [1:0] st);
    mbd_res_t r;
    r.frame_byte = b;
    r.byte_index = idx;
    r.last       = lst;
    r.status     = st;
    frame_results.push_back(r);
  endfunction

  function automatic void predict_frame_byte(input logic [7:0] b);
    case (parse_phase)
      HUNT_ADDR: if (b == addr_cfg) parse_phase = HUNT_FUNC;
      HUNT_FUNC: begin
        if (b == func_cfg) begin
          frame_crc = crc_fold(crc_fold(CRC_INIT, addr_cfg), b);
          add_frame_result(addr_cfg, 9'd0, 1'b0, ST_BUSY);
          add_frame_result(b, 9'd1, 1'b0, ST_BUSY);
          frame_pos   = 9'd2;
          parse_phase = TAKE_COUNT;
        end else if (b != addr_cfg) begin
          parse_phase = HUNT_ADDR;
        end
      end
      TAKE_COUNT: begin
        frame_crc = crc_fold(frame_crc, b);
        add_frame_result(b, frame_pos, 1'b0, ST_BUSY);
        frame_pos++;
        payload_left = (b > PAYLOAD_LIMIT) ? 9'(PAYLOAD_LIMIT) : {1'b0, b};
        parse_phase  = (payload_left == 0) ? TAKE_CRC_LO : TAKE_PAYLOAD;
      end
      TAKE_PAYLOAD: begin
        frame_crc = crc_fold(frame_crc, b);
        add_frame_result(b, frame_pos, 1'b0, ST_BUSY);
        frame_pos++;
        if (payload_left != 0) payload_left--;
        if (payload_left == 0) parse_phase = TAKE_CRC_LO;
      end
      TAKE_CRC_LO: begin
        crc_lo_rx = b;
        add_frame_result(b, frame_pos, 1'b0, ST_BUSY);
        frame_pos++;
        parse_phase = TAKE_CRC_HI;
      end
      TAKE_CRC_HI: begin
        add_frame_result(b, frame_pos, 1'b1,
                         (crc_lo_rx == frame_crc[7:0] && b == frame_crc[15:8]) ?
                         ST_GOOD : ST_CRC_ERR);
        restart_hunt();
        timer_armed = 1'b0;
      end
      default: restart_hunt();
    endcase
  endfunction

  function automatic void predict_deframe(input logic [1:0] cmd, input logic [7:0] b);
    requests_counted++;
    if (cmd == CMD_BYTE) begin
      predict_frame_byte(b);
    end else if (cmd == CMD_START) begin
      timer_armed = 1'b1;
      tick_cnt    = '0;
    end else if (cmd == CMD_TICK && timer_armed) begin
      if (tick_cnt != 16'hFFFF) tick_cnt++;
      if (tick_cnt >= tmo_cfg) begin
        timer_armed = 1'b0;
        add_frame_result(8'h00, 9'd0, 1'b1, ST_TIMEOUT);
      end
    end
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < 12) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_deframe(cmd, b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (sprinkle_timer) begin
      if ($urandom_range(99) < 10) send_request(CMD_TICK, 8'($urandom));
      if ($urandom_range(99) < 3) send_request(CMD_START, 8'($urandom));
    end
    send_request(CMD_BYTE, b);
  endtask

  // Build address, function, count, payload and CRC; send only the first cut bytes.
  task automatic send_frame(input int unsigned count, input bit bad_crc,
                            input int unsigned cut);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    int unsigned k;
    crc = CRC_INIT;
    fb.push_back(addr_cfg);
    fb.push_back(func_cfg);
    fb.push_back(8'(count));
    repeat (count) fb.push_back(8'($urandom));
    foreach (fb[i]) crc = crc_fold(crc, fb[i]);
    if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(15));
    fb.push_back(crc[7:0]);
    fb.push_back(crc[15:8]);
    for (k = 0; k < fb.size() && k < cut; k++) send_byte(fb[k]);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [7:0] addr, input logic [7:0] func,
                             input logic [15:0] tmo);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_DEV_ADDR;
    cfg_data_i  <= {8'($urandom), addr};
    @(posedge clk_i);
    cfg_index_i <= REG_FUNC_CODE;
    cfg_data_i  <= {8'($urandom), func};
    @(posedge clk_i);
    cfg_index_i <= REG_TIMEOUT;
    cfg_data_i  <= tmo;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    addr_cfg = addr;
    func_cfg = func;
    tmo_cfg  = tmo;
    configs_loaded++;
  endtask

  task automatic send_random_episode();
    int unsigned pick;
    int unsigned count;
    pick  = $urandom_range(99);
    count = ($urandom_range(99) < 2) ? $urandom_range(PAYLOAD_LIMIT) : $urandom_range(8);
    if ($urandom_range(1)) send_request(CMD_START, 8'($urandom));
    if (pick < 65) begin
      send_frame(count, 1'b0, WHOLE_FRAME);
    end else if (pick < 80) begin
      send_frame(count, 1'b1, WHOLE_FRAME);
    end else if (pick < 90) begin
      send_frame(count, 1'($urandom), $urandom_range(1, count + 4));
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 40)) send_request(CMD_TICK, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 12)) send_request(2'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_header_hunt();
    send_request(CMD_BYTE, 8'h00);
    send_request(CMD_BYTE, DEV_ADDR_RST);
    send_request(CMD_BYTE, 8'h07);
    send_request(CMD_BYTE, DEV_ADDR_RST);
    send_frame(2, 1'b0, WHOLE_FRAME);
    wait_idle();
  endtask

  task automatic test_crc_check();
    send_frame(1, 1'b1, WHOLE_FRAME);
    send_frame(0, 1'b1, WHOLE_FRAME);
    send_frame(0, 1'b0, WHOLE_FRAME);
    wait_idle();
  endtask

  task automatic test_timer_commands();
    send_request(CMD_TICK, 8'hFF);
    send_request(CMD_UNUSED, 8'hFF);
    send_request(CMD_START, 8'h00);
    repeat (2) send_request(CMD_TICK, 8'h00);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    load_config(8'h00, 8'h00, 16'd1);
    send_request(CMD_TICK, 8'h00);
    send_frame(3, 1'b0, WHOLE_FRAME);
    send_request(CMD_START, 8'h00);
    send_request(CMD_TICK, 8'h00);
    wait_idle();
    load_config(8'hFF, 8'hFF, 16'd0);
    send_frame(1, 1'b0, WHOLE_FRAME);
    send_request(CMD_START, 8'hFF);
    send_request(CMD_TICK, 8'hFF);
    wait_idle();
    load_config(8'h5A, 8'hA5, 16'hFFFF);
    send_request(CMD_START, 8'h00);
    repeat (20) send_request(CMD_TICK, 8'h00);
    send_frame(2, 1'b1, WHOLE_FRAME);
    send_request(CMD_TICK, 8'h00);
    wait_idle();
    load_config(8'h11, 8'h22, 16'd5);
    send_request(CMD_START, 8'h00);
    repeat (4) send_request(CMD_TICK, 8'h00);
    send_request(CMD_START, 8'h00);
    repeat (5) send_request(CMD_TICK, 8'h00);
    wait_idle();
  endtask

  task automatic test_longest_frame();
    load_config(8'($urandom), 8'($urandom), 16'd300);
    sprinkle_timer = 1'b1;
    send_request(CMD_START, 8'h00);
    send_frame(PAYLOAD_LIMIT, 1'b0, WHOLE_FRAME);
    sprinkle_timer = 1'b0;
    wait_idle();
  endtask

  task automatic test_back_pressure();
    -> hold_trigger;
    repeat (6) send_frame($urandom_range(8), 1'b0, WHOLE_FRAME);
    wait_idle();
  endtask

  task automatic test_back_to_back();
    int unsigned stop_at;
    stop_at = requests_counted + 200;
    load_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 40)));
    idle_on        = 1'b0;
    sprinkle_timer = 1'b1;
    while (requests_counted < stop_at) send_random_episode();
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int unsigned n_phases);
    int unsigned stop_at;
    sprinkle_timer = 1'b1;
    for (int unsigned p = 0; p < n_phases; p++) begin
      stop_at = requests_counted + (TOTAL_REQUESTS - requests_counted) / (n_phases - p);
      load_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 40)));
      while (requests_counted < stop_at) send_random_episode();
      wait_idle();
    end
    sprinkle_timer = 1'b0;
  endtask

  always begin
    @(hold_trigger);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_active) out_ready_i <= 1'b0;
    else if (!idle_on) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (frame_results.size() == 0) begin
        $error("unexpected result: frame_byte %0h byte_index %0d status %0d",
               frame_byte_o, byte_index_o, status_o);
        mismatches++;
      end else begin
        next_result = frame_results.pop_front();
        if (frame_byte_o !== next_result.frame_byte) begin
          $error("frame_byte: expected %0h, got %0h", next_result.frame_byte, frame_byte_o);
          mismatches++;
        end
        if (byte_index_o !== next_result.byte_index) begin
          $error("byte_index: expected %0d, got %0d", next_result.byte_index, byte_index_o);
          mismatches++;
        end
        if (last_o !== next_result.last) begin
          $error("last: expected %0b, got %0b", next_result.last, last_o);
          mismatches++;
        end
        if (status_o !== next_result.status) begin
          $error("status: expected %0d, got %0d", next_result.status, status_o);
          mismatches++;
        end
        case (next_result.status)
          ST_GOOD:    good_frames++;
          ST_CRC_ERR: crc_errors++;
          ST_TIMEOUT: timeouts++;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    reset_prediction();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_hunt();
    test_crc_check();
    test_timer_commands();
    test_config_extremes();
    test_longest_frame();
    test_back_pressure();
    test_back_to_back();
    test_random_traffic(4);
    $display("Sent %0d requests under %0d register settings; checked %0d results.",
             requests_counted, configs_loaded, results_seen);
    $display("Good frames %0d, CRC errors %0d, timeouts %0d, with a %0d-cycle output stall.",
             good_frames, crc_errors, timeouts, HOLD_CYCLES);
    if (mismatches == 0 && frame_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
